// ===== sv/dimc_pkg.sv =====
package dimc_pkg;

   localparam int TIME_BITS_DEFAULT = 24;

   // request kinds carried in req_tuser
   localparam logic [2:0] REQ_DIM_TICK  = 3'd0;
   localparam logic [2:0] REQ_IDLE_TICK = 3'd1;
   localparam logic [2:0] REQ_SLEEP     = 3'd2;
   localparam logic [2:0] REQ_WAKE      = 3'd3;
   localparam logic [2:0] REQ_ACTIVITY  = 3'd4;

   // configuration register indexes
   localparam logic [2:0] CSR_WAKE_TIMEOUT  = 3'd0;
   localparam logic [2:0] CSR_USER_BRIGHT   = 3'd1;
   localparam logic [2:0] CSR_DIM_PERCENT   = 3'd2;
   localparam logic [2:0] CSR_TOUCH_BRIGHT  = 3'd3;
   localparam logic [2:0] CSR_TOUCH_OFF     = 3'd4;
   localparam logic [2:0] CSR_MONITOR_AFTER = 3'd5;

   // panel power commands
   localparam logic [1:0] PWR_NONE = 2'd0;
   localparam logic [1:0] PWR_DOWN = 2'd1;
   localparam logic [1:0] PWR_UP   = 2'd2;

   localparam logic TOUCH_ACTIVE  = 1'b0;
   localparam logic TOUCH_MONITOR = 1'b1;

   localparam int WAKE_TIMEOUT_RESET  = 30000;
   localparam int TOUCH_BRIGHT_RESET  = 5000;
   localparam int TOUCH_OFF_RESET     = 10000;
   localparam int MONITOR_AFTER_RESET = 10000;
   localparam logic [7:0] USER_BRIGHT_RESET = 8'd255;
   localparam logic [6:0] DIM_PERCENT_RESET = 7'd30;
   localparam int MIN_WAKE_TIMEOUT = 2;

   // x / 100 == (x * 5243) >> 19, exact for x < 43690
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   typedef struct packed {
      logic [7:0]  user_brightness;
      logic [14:0] dim_product;     // user_brightness * dim_percent
   } dimc_cfg_type;

   // first member lands in the highest bits
   typedef struct packed {
      logic       display_is_on;
      logic [1:0] panel_power;
      logic       touch_mode;
      logic       touch_mode_valid;
      logic       sleep_request;
      logic [7:0] brightness;
      logic       brightness_valid;
   } dimc_rsp_type;

endpackage

// ===== sv/dimc_csr.sv =====
module dimc_csr #(
   parameter int TIME_BITS = dimc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [TIME_BITS-1:0] csr_wdata,
   output logic [TIME_BITS-1:0] wake_timeout,
   output logic [TIME_BITS-1:0] touch_bright,
   output logic [TIME_BITS-1:0] touch_off,
   output logic [TIME_BITS-1:0] monitor_after,
   output dimc_pkg::dimc_cfg_type cfg
);

   logic [TIME_BITS-1:0] wake_timeout_ff, touch_bright_ff, touch_off_ff, monitor_after_ff;
   logic [7:0]  user_bright_ff;
   logic [6:0]  dim_percent_ff;
   logic [14:0] dim_product_ff, dim_product_in;

   // product is registered so the step path holds only the divide-by-100 multiply
   assign dim_product_in = 15'(user_bright_ff) * 15'(dim_percent_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_timeout_ff  <= TIME_BITS'(dimc_pkg::WAKE_TIMEOUT_RESET);
         user_bright_ff   <= dimc_pkg::USER_BRIGHT_RESET;
         dim_percent_ff   <= dimc_pkg::DIM_PERCENT_RESET;
         touch_bright_ff  <= TIME_BITS'(dimc_pkg::TOUCH_BRIGHT_RESET);
         touch_off_ff     <= TIME_BITS'(dimc_pkg::TOUCH_OFF_RESET);
         monitor_after_ff <= TIME_BITS'(dimc_pkg::MONITOR_AFTER_RESET);
         dim_product_ff   <= 15'(dimc_pkg::USER_BRIGHT_RESET) *
                             15'(dimc_pkg::DIM_PERCENT_RESET);
      end else begin
         dim_product_ff <= dim_product_in;
         if (csr_we) begin
            unique case (csr_index)
               dimc_pkg::CSR_WAKE_TIMEOUT:  wake_timeout_ff  <= csr_wdata;
               dimc_pkg::CSR_USER_BRIGHT:   user_bright_ff   <= csr_wdata[7:0];
               dimc_pkg::CSR_DIM_PERCENT:   dim_percent_ff   <= csr_wdata[6:0];
               dimc_pkg::CSR_TOUCH_BRIGHT:  touch_bright_ff  <= csr_wdata;
               dimc_pkg::CSR_TOUCH_OFF:     touch_off_ff     <= csr_wdata;
               dimc_pkg::CSR_MONITOR_AFTER: monitor_after_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign wake_timeout        = wake_timeout_ff;
   assign touch_bright        = touch_bright_ff;
   assign touch_off           = touch_off_ff;
   assign monitor_after       = monitor_after_ff;
   assign cfg.user_brightness = user_bright_ff;
   assign cfg.dim_product     = dim_product_ff;

endmodule

// ===== sv/dimc_core.sv =====
module dimc_core #(
   parameter int TIME_BITS = dimc_pkg::TIME_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [2:0]             req_type,
   input  logic [TIME_BITS-1:0]   inactive_ms,
   input  logic                   mode_write_ok,
   input  logic [TIME_BITS-1:0]   wake_timeout,
   input  logic [TIME_BITS-1:0]   touch_bright,
   input  logic [TIME_BITS-1:0]   touch_off,
   input  logic [TIME_BITS-1:0]   monitor_after,
   input  dimc_pkg::dimc_cfg_type cfg,
   output dimc_pkg::dimc_rsp_type rsp
);

   logic panel_on_ff, panel_on_in;
   logic touch_cycle_ff, touch_cycle_in;
   logic dimmed_ff, dimmed_in;
   logic monitor_ff, monitor_in;
   logic [TIME_BITS-1:0] prev_ff, prev_in;
   logic [7:0] saved_ff, saved_in;

   logic [TIME_BITS-1:0] wake_eff, off_at, dim_at;
   logic [27:0] scaled;
   logic [8:0]  lvl_raw;
   logic [7:0]  lvl_clamped;
   logic        activity, dimmed_mid;

   assign scaled  = 28'(cfg.dim_product) * 28'(dimc_pkg::DIV100_MUL);
   assign lvl_raw = scaled[dimc_pkg::DIV100_SHIFT +: 9];

   always_comb begin
      if (lvl_raw > 9'd255)     lvl_clamped = 8'd255;
      else if (lvl_raw == 9'd0) lvl_clamped = 8'd1;
      else                      lvl_clamped = lvl_raw[7:0];
   end

   assign wake_eff = (wake_timeout < TIME_BITS'(dimc_pkg::MIN_WAKE_TIMEOUT)) ?
                     TIME_BITS'(dimc_pkg::MIN_WAKE_TIMEOUT) : wake_timeout;
   assign activity = inactive_ms < prev_ff;

   always_comb begin
      panel_on_in    = panel_on_ff;
      touch_cycle_in = touch_cycle_ff;
      dimmed_in      = dimmed_ff;
      monitor_in     = monitor_ff;
      prev_in        = prev_ff;
      saved_in       = saved_ff;
      dimmed_mid     = dimmed_ff;
      off_at         = wake_eff;
      dim_at         = wake_eff >> 1;
      rsp            = '0;

      unique case (req_type)
         dimc_pkg::REQ_DIM_TICK: begin
            if (panel_on_ff) begin
               prev_in = inactive_ms;
               if (activity) begin
                  touch_cycle_in = 1'b1;
                  if (dimmed_ff) begin
                     rsp.brightness_valid = 1'b1;
                     rsp.brightness       = saved_ff;
                     dimmed_mid           = 1'b0;
                  end
               end
               dimmed_in = dimmed_mid;
               if (touch_cycle_in) begin
                  off_at = touch_off;
                  dim_at = touch_bright;
               end
               if (inactive_ms >= off_at) begin
                  rsp.sleep_request = 1'b1;
               end else if (!dimmed_mid && inactive_ms >= dim_at) begin
                  saved_in             = cfg.user_brightness;
                  rsp.brightness_valid = 1'b1;
                  rsp.brightness       = lvl_clamped;
                  dimmed_in            = 1'b1;
               end
            end
         end
         dimc_pkg::REQ_IDLE_TICK: begin
            if (panel_on_ff && !monitor_ff && inactive_ms >= monitor_after) begin
               rsp.touch_mode_valid = 1'b1;
               rsp.touch_mode       = dimc_pkg::TOUCH_MONITOR;
               if (mode_write_ok) monitor_in = 1'b1;
            end
         end
         dimc_pkg::REQ_SLEEP: begin
            if (panel_on_ff) begin
               rsp.touch_mode_valid = 1'b1;
               rsp.touch_mode       = dimc_pkg::TOUCH_MONITOR;
               rsp.brightness_valid = 1'b1;
               rsp.panel_power      = dimc_pkg::PWR_DOWN;
               dimmed_in            = 1'b0;
               touch_cycle_in       = 1'b0;
               prev_in              = '0;
               monitor_in           = 1'b0;
               panel_on_in          = 1'b0;
            end
         end
         dimc_pkg::REQ_WAKE: begin
            if (!panel_on_ff) begin
               rsp.panel_power      = dimc_pkg::PWR_UP;
               rsp.brightness_valid = 1'b1;
               rsp.brightness       = cfg.user_brightness;
               rsp.touch_mode_valid = 1'b1;
               rsp.touch_mode       = dimc_pkg::TOUCH_ACTIVE;
               touch_cycle_in       = 1'b0;
               prev_in              = '0;
               dimmed_in            = 1'b0;
               monitor_in           = 1'b0;
               panel_on_in          = 1'b1;
            end
         end
         dimc_pkg::REQ_ACTIVITY: monitor_in = 1'b0;
         default: ;
      endcase

      rsp.display_is_on = panel_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_on_ff    <= 1'b1;
         touch_cycle_ff <= 1'b0;
         dimmed_ff      <= 1'b0;
         monitor_ff     <= 1'b0;
         prev_ff        <= '0;
         saved_ff       <= '0;
      end else if (step_en) begin
         panel_on_ff    <= panel_on_in;
         touch_cycle_ff <= touch_cycle_in;
         dimmed_ff      <= dimmed_in;
         monitor_ff     <= monitor_in;
         prev_ff        <= prev_in;
         saved_ff       <= saved_in;
      end
   end

   // with the panel off no dim, touch-cycle or inactivity state may be left over from the last on period
   a_off_clean: assert property (@(posedge clock) disable iff (reset)
      !panel_on_ff |-> (!dimmed_ff && !touch_cycle_ff && prev_ff == '0))
      else $error("stale dim state while panel is off");

endmodule

// ===== sv/display_idle_dim_controller.sv =====
// Display idle dim controller.
// req_* channel: one transaction per event. req_tuser carries the request kind
// (dim tick, touch idle tick, sleep, wake, external activity), req_tdata the
// inactivity time and the monitor mode write outcome.
// rsp_* channel: exactly one result per request, in order: brightness command,
// sleep request, touch mode write, panel power command and the display-on flag.
// csr_* port: write-only configuration, taken at any edge with csr_we high;
// write only while no request is in flight.
// Each request passes through the input register, then the step logic into the result
// register, where rsp_tvalid is raised. Throughput: one transaction per cycle while
// rsp_tready is high; the state update and the divide-by-100 multiply fit in a single step.
// A changed brightness or percent takes effect for requests accepted from the
// cycle after the write.
// Reset (synchronous, active high): panel on, wake cycle, not dimmed, monitor
// flag clear, configuration at its defaults, both pipeline stages empty.
// When rsp_tready is low, the result holds and one more request is taken into
// the input register; after that req_tready drops until the result is taken.
module display_idle_dim_controller #(
   parameter int TIME_BITS = dimc_pkg::TIME_BITS_DEFAULT,
   localparam int REQ_DATA_W = ((TIME_BITS + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // inactive_ms, mode_write_ok
   input  logic [2:0]            req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // brightness_valid, brightness, sleep_request, touch_mode_valid, touch_mode,
   // panel_power, display_is_on
   output logic [15:0]           rsp_tdata,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [TIME_BITS-1:0]  csr_wdata
);

   logic                 in_valid_ff;
   logic [2:0]           type_ff;
   logic [TIME_BITS-1:0] inactive_ff;
   logic                 write_ok_ff;
   logic                 out_valid_ff;
   dimc_pkg::dimc_rsp_type rsp_ff, rsp_in;

   logic out_free, step_en, req_fire;
   logic [TIME_BITS-1:0] wake_timeout, touch_bright, touch_off, monitor_after;
   dimc_pkg::dimc_cfg_type cfg;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   dimc_csr #(.TIME_BITS(TIME_BITS)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .wake_timeout  (wake_timeout),
      .touch_bright  (touch_bright),
      .touch_off     (touch_off),
      .monitor_after (monitor_after),
      .cfg           (cfg)
   );

   dimc_core #(.TIME_BITS(TIME_BITS)) u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .req_type      (type_ff),
      .inactive_ms   (inactive_ff),
      .mode_write_ok (write_ok_ff),
      .wake_timeout  (wake_timeout),
      .touch_bright  (touch_bright),
      .touch_off     (touch_off),
      .monitor_after (monitor_after),
      .cfg           (cfg),
      .rsp           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire)      in_valid_ff <= 1'b1;
         else if (step_en)  in_valid_ff <= 1'b0;
         if (step_en)       out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff     <= req_tuser;
         inactive_ff <= req_tdata[TIME_BITS-1:0];
         write_ok_ff <= req_tdata[TIME_BITS];
      end
      if (step_en) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("stepped transaction did not reach the result register");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input stage empty but request not ready");

   a_power_up_on: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_ff.panel_power == dimc_pkg::PWR_UP) |-> rsp_ff.display_is_on)
      else $error("power up reported with display off");

endmodule
